@@ rtl/stop_symbol_escape_encoder_core_defines.svh @@
// Assertion macros shared by the stop symbol escape encoder RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef STOP_SYMBOL_ESCAPE_ENCODER_CORE_DEFINES_SVH
`define STOP_SYMBOL_ESCAPE_ENCODER_CORE_DEFINES_SVH

// Check that holds in the same cycle as its trigger.
`define SSEE_ASSERT_NOW(lbl, trig, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (expr)) \
    else $error(msg);

// Check that holds in the cycle after its trigger.
`define SSEE_ASSERT_NEXT(lbl, trig, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
    else $error(msg);

`endif

@@ rtl/ssee_pkg.sv @@
// Shared types, constants and helpers of the stop symbol escape encoder.
// No dependencies; imported by ssee_match and the top level.
`default_nettype none

package ssee_pkg;

  localparam int BYTE_W        = 8;
  localparam int SLOT_LIMIT    = 16;
  localparam int DEF_MAX_STOPS = 16;
  localparam int SLOT_IDX_W    = 4;
  localparam int CNT_W         = 5;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_CHAR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_SYM_LO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_SYM_HI  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LO   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE_HI   = 3'd5;

  // Result of the match stages, handed to the output stage.
  typedef struct packed {
    logic [BYTE_W-1:0]     data;
    logic                  eos;
    logic                  hit;
    logic [SLOT_IDX_W-1:0] slot;
  } match_t;

  // Picks the byte of one slot out of a low and high pair of 64-bit words.
  function automatic logic [BYTE_W-1:0] slot_byte(input logic [CFG_DATA_W-1:0] lo,
                                                  input logic [CFG_DATA_W-1:0] hi,
                                                  input logic [SLOT_IDX_W-1:0] slot);
    logic [CFG_DATA_W-1:0] word;
    word = slot[SLOT_IDX_W-1] ? hi : lo;
    return word[{slot[SLOT_IDX_W-2:0], 3'b000} +: BYTE_W];
  endfunction

endpackage

`default_nettype wire

@@ rtl/ssee_match.sv @@
// Two-stage stop symbol matcher: parallel compare, then lowest-slot pick.
// Depends on ssee_pkg and the assertion macro header.
`default_nettype none
`include "stop_symbol_escape_encoder_core_defines.svh"

module ssee_match #(
  parameter int MAX_STOPS = ssee_pkg::DEF_MAX_STOPS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [ssee_pkg::BYTE_W-1:0]       in_tdata,
  input  wire logic                              in_tlast,
  input  wire logic [ssee_pkg::BYTE_W-1:0]       escape_char,
  input  wire logic [ssee_pkg::CNT_W-1:0]        stop_count,
  input  wire logic [ssee_pkg::CFG_DATA_W-1:0]   stop_lo,
  input  wire logic [ssee_pkg::CFG_DATA_W-1:0]   stop_hi,
  output logic                                   m_valid,
  input  wire logic                              m_ready,
  output ssee_pkg::match_t                       m_item
);
  import ssee_pkg::*;

  logic                 s1_valid_r;
  logic [BYTE_W-1:0]    s1_data_r;
  logic                 s1_eos_r;
  logic [MAX_STOPS-1:0] s1_hit_r;
  logic [MAX_STOPS-1:0] s1_hit_nxt;
  logic                 s2_valid_r;
  match_t               s2_item_r;
  match_t               s2_item_nxt;
  logic                 s1_adv;
  logic                 s2_adv;
  logic                 esc_en;

  // A stage takes a new beat when it is empty or its content moves on.
  assign s2_adv    = !s2_valid_r || m_ready;
  assign s1_adv    = !s1_valid_r || s2_adv;
  assign in_tready = s1_adv;
  assign esc_en    = (escape_char != '0);

  // Compare the byte against every active slot in parallel.
  always_comb begin
    for (int i = 0; i < MAX_STOPS; i++) begin
      s1_hit_nxt[i] = esc_en && (stop_count > CNT_W'(i)) &&
                      (slot_byte(stop_lo, stop_hi, SLOT_IDX_W'(i)) == in_tdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_tvalid) begin
      s1_data_r <= in_tdata;
      s1_eos_r  <= in_tlast;
      s1_hit_r  <= s1_hit_nxt;
    end
  end

  // The lowest matching slot wins.
  always_comb begin
    s2_item_nxt.data = s1_data_r;
    s2_item_nxt.eos  = s1_eos_r;
    s2_item_nxt.hit  = |s1_hit_r;
    s2_item_nxt.slot = '0;
    for (int i = MAX_STOPS - 1; i >= 0; i--) begin
      if (s1_hit_r[i]) begin
        s2_item_nxt.slot = SLOT_IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid_r) begin
      s2_item_r <= s2_item_nxt;
    end
  end

  assign m_valid = s2_valid_r;
  assign m_item  = s2_item_r;

  // An empty first stage always takes a beat.
  `SSEE_ASSERT_NOW(a_s1_empty_ready, !s1_valid_r, in_tready, "empty stage 1 not ready")
  // With escaping off, no slot may report a match.
  `SSEE_ASSERT_NOW(a_no_hit_when_off, s1_valid_r && (escape_char == '0), s1_hit_r == '0,
    "match reported while escaping is disabled")
  // A stalled second stage keeps its beat.
  `SSEE_ASSERT_NEXT(a_s2_hold, s2_valid_r && !m_ready, s2_valid_r && $stable(s2_item_r),
    "stage 2 beat lost under stall")

endmodule

`default_nettype wire

@@ rtl/stop_symbol_escape_encoder_core.sv @@
// Stop symbol escape encoder: bytes in, escaped bytes out.
//
// Input channel in_*: one string byte per beat, in_tlast marks the last byte
// of the string. Output channel out_*: one output byte per beat, out_tlast
// marks the final byte of the string, out_tuser marks the last byte caused
// by an input byte. A byte equal to an active stop symbol comes out as two
// beats: the escape character, then the replacement byte of the lowest
// matching slot. An escape character of zero passes every byte unchanged.
// Configuration port cfg_*: register index and 64-bit data, always ready;
// write only while no beat is in flight.
// An input beat passes the compare stage, the slot select stage and the
// output register in that order. Throughput: one input byte per cycle for
// plain bytes while out_tready is high; an escaped byte holds the output
// register for both of its beats, which stalls the input behind it.
// Reset clears all configuration registers to zero and empties the pipeline.
// When out_tready is low the output register holds its beat and the stall
// backs up stage by stage; bubbles close up, nothing is lost or repeated.
`default_nettype none
`include "stop_symbol_escape_encoder_core_defines.svh"

module stop_symbol_escape_encoder_core #(
  parameter int MAX_STOPS = ssee_pkg::DEF_MAX_STOPS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input stream.
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [ssee_pkg::BYTE_W-1:0]       in_tdata,  // [7:0] data_byte
  input  wire logic                              in_tlast,  // end_of_string
  // Output stream.
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [ssee_pkg::BYTE_W-1:0]            out_tdata, // [7:0] out_byte
  output logic                                   out_tuser, // [0] run_last
  output logic                                   out_tlast, // string_done
  // Configuration writes.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ssee_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ssee_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ssee_pkg::*;

  logic [BYTE_W-1:0]     escape_char_r;
  logic [CNT_W-1:0]      stop_count_r;
  logic [CFG_DATA_W-1:0] stop_lo_r;
  logic [CFG_DATA_W-1:0] stop_hi_r;
  logic [CFG_DATA_W-1:0] repl_lo_r;
  logic [CFG_DATA_W-1:0] repl_hi_r;

  logic                  m_valid;
  logic                  m_ready;
  match_t                m_item;

  logic                  out_valid_r;
  logic [BYTE_W-1:0]     out_byte_r;
  logic                  out_last_r;
  logic                  out_done_r;
  logic                  pend_r;
  logic [BYTE_W-1:0]     pend_byte_r;
  logic                  pend_eos_r;
  logic                  out_fire;
  logic                  load;
  logic [BYTE_W-1:0]     repl_byte;

  // Configuration registers; unknown indexes are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_char_r <= '0;
      stop_count_r  <= '0;
      stop_lo_r     <= '0;
      stop_hi_r     <= '0;
      repl_lo_r     <= '0;
      repl_hi_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ESCAPE_CHAR: escape_char_r <= cfg_data[BYTE_W-1:0];
        REG_STOP_COUNT:  stop_count_r  <= cfg_data[CNT_W-1:0];
        REG_STOP_SYM_LO: stop_lo_r     <= cfg_data;
        REG_STOP_SYM_HI: stop_hi_r     <= cfg_data;
        REG_REPLACE_LO:  repl_lo_r     <= cfg_data;
        REG_REPLACE_HI:  repl_hi_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Compare and slot select stages.
  ssee_match #(
    .MAX_STOPS (MAX_STOPS)
  ) u_match (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .escape_char (escape_char_r),
    .stop_count  (stop_count_r),
    .stop_lo     (stop_lo_r),
    .stop_hi     (stop_hi_r),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_item      (m_item)
  );

  // The output register frees up after the last beat of its item.
  assign out_fire = out_valid_r && out_tready;
  assign m_ready  = !out_valid_r || (out_fire && out_last_r);
  assign load     = m_ready && m_valid;
  assign repl_byte = slot_byte(repl_lo_r, repl_hi_r, m_item.slot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      pend_r      <= m_item.hit;
    end else if (out_fire) begin
      out_valid_r <= pend_r;
      pend_r      <= 1'b0;
    end
  end

  // Escape pair: escape byte first, replacement byte queued behind it.
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r  <= m_item.hit ? escape_char_r : m_item.data;
      out_last_r  <= !m_item.hit;
      out_done_r  <= !m_item.hit && m_item.eos;
      pend_byte_r <= repl_byte;
      pend_eos_r  <= m_item.eos;
    end else if (out_fire && pend_r) begin
      out_byte_r  <= pend_byte_r;
      out_last_r  <= 1'b1;
      out_done_r  <= pend_eos_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_last_r;
  assign out_tlast  = out_done_r;

  // An accepted escape byte is always followed by its replacement beat.
  `SSEE_ASSERT_NEXT(a_pair_follows, out_fire && !out_tuser, out_tvalid && out_tuser,
    "escape byte not followed by replacement")
  // The first beat of a pair carries the escape character and never ends a string.
  `SSEE_ASSERT_NOW(a_escape_beat, out_tvalid && !out_tuser,
    (out_tdata == escape_char_r) && !out_tlast, "bad escape beat")
  // End of string only appears on the last beat of an input byte.
  `SSEE_ASSERT_NOW(a_done_is_last, out_tvalid && out_tlast, out_tuser,
    "string end on a non-final beat")

endmodule

`default_nettype wire
